@@ src/fabs_pkg.sv @@
// ----------------------------------------------------------------------------
// fabs_pkg
// shared types and constants of the four-axis bresenham step generator
// ----------------------------------------------------------------------------
`default_nettype none

package fabs_pkg;

    // input command codes
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_STEP    = 2'd1;
    localparam logic [1:0] CMD_SET_POS = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_ABS_MODE    = 3'd0;
    localparam logic [2:0] REG_FEED_RATE   = 3'd1;
    localparam logic [2:0] REG_SPM_X       = 3'd2;
    localparam logic [2:0] REG_SPM_Y       = 3'd3;
    localparam logic [2:0] REG_SPM_Z       = 3'd4;
    localparam logic [2:0] REG_SPM_E       = 3'd5;
    localparam logic [2:0] REG_START_HP    = 3'd6;
    localparam logic [2:0] REG_RAMP_FACTOR = 3'd7;

    // axis codes
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // cruise numerator, quotient width and last divider iteration
    localparam int          QUO_BITS   = 25;
    localparam logic [24:0] CRUISE_NUM = 25'd30000000;
    localparam logic [4:0]  DIV_LAST   = 5'd24;

    typedef struct packed {
        logic        abs_mode;
        logic [15:0] feed_rate;
        logic [11:0] spm_x;
        logic [11:0] spm_y;
        logic [11:0] spm_z;
        logic [11:0] spm_e;
        logic [15:0] start_hp;
        logic [15:0] ramp_factor;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic set_pos;
        logic res_idle;
        logic ld_calc;
        logic ld_mag;
        logic ld_minor;
        logic ld_div;
        logic div_step;
        logic st_calc;
        logic st_period;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic steps_zero;
        logic div_done;
    } dp_stat_t;

endpackage

`default_nettype wire

@@ src/fabs_if.sv @@
// ----------------------------------------------------------------------------
// fabs_if
// valid/ready channels for command beats and result beats
// ----------------------------------------------------------------------------
`default_nettype none

interface fabs_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [3:0]  axis_mask;
    logic signed [23:0] target_x;
    logic signed [23:0] target_y;
    logic signed [23:0] target_z;
    logic signed [23:0] target_e;

    modport source (output valid, cmd, axis_mask, target_x, target_y, target_z, target_e,
                    input ready);
    modport sink   (input valid, cmd, axis_mask, target_x, target_y, target_z, target_e,
                    output ready);
endinterface

interface fabs_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  step_bits;
    logic [3:0]  dir_bits;
    logic [24:0] half_period;
    logic        last_step;
    logic        busy_res;

    modport source (output valid, step_bits, dir_bits, half_period, last_step, busy_res,
                    input ready);
    modport sink   (input valid, step_bits, dir_bits, half_period, last_step, busy_res,
                    output ready);
endinterface

`default_nettype wire

@@ src/four_axis_bresenham_stepper_top.sv @@
// ----------------------------------------------------------------------------
// four_axis_bresenham_stepper_top
// four-axis bresenham step generator with cruise period and corner ramp
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries one command beat (load line, step, set positions), out_ch
//   returns exactly one result beat per command. apb configuration, at byte
//   4*index, is to be written by the user while the block is idle; unchecked.
// sequencing:
//   one command at a time. load line: setup, then the restoring divider
//   for the cruise half-period. step: error update and the Q0.16 ramp
//   multiply, then the period update. set positions, idle steps and
//   command 3 go straight to the result.
//   the next command is taken the cycle after the result beat leaves.
// reset:
//   positions, line state and period state clear, directions go all ones,
//   configuration registers take their reset values; no clearing pass.
// stall:
//   the result beat holds in its output register while out_ch.ready is low
//   and in_ch.ready stays low until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module four_axis_bresenham_stepper_top #(
    parameter int POS_BITS = 24
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    fabs_in_if.sink           in_ch,
    fabs_out_if.source        out_ch,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import fabs_pkg::*;

    cfg_t     cfg;      // live configuration
    dp_cmd_t  dp_cmd;   // sequencer commands into the datapath
    dp_stat_t dp_stat;  // line empty, divider finished

    fabs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer owns both handshakes
    fabs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_cmd    (in_ch.cmd),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    // datapath holds positions, line state and the result register
    fabs_dp #(
        .POS_BITS (POS_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (dp_cmd),
        .stat        (dp_stat),
        .axis_mask   (in_ch.axis_mask),
        .target_x    (in_ch.target_x),
        .target_y    (in_ch.target_y),
        .target_z    (in_ch.target_z),
        .target_e    (in_ch.target_e),
        .step_bits   (out_ch.step_bits),
        .dir_bits    (out_ch.dir_bits),
        .half_period (out_ch.half_period),
        .last_step   (out_ch.last_step),
        .busy_res    (out_ch.busy_res)
    );

endmodule

`default_nettype wire

@@ src/fabs_regs.sv @@
// ----------------------------------------------------------------------------
// fabs_regs
// apb configuration register file
// ----------------------------------------------------------------------------
`default_nettype none

module fabs_regs (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output fabs_pkg::cfg_t    cfg
);
    import fabs_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] idx;
    logic       wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.abs_mode    <= 1'b1;
            cfg_reg.feed_rate   <= 16'd500;
            cfg_reg.spm_x       <= 12'd80;
            cfg_reg.spm_y       <= 12'd80;
            cfg_reg.spm_z       <= 12'd400;
            cfg_reg.spm_e       <= 12'd100;
            cfg_reg.start_hp    <= 16'd300;
            cfg_reg.ramp_factor <= 16'd64880;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_ABS_MODE:    cfg_reg.abs_mode    <= pwdata[0];
                REG_FEED_RATE:   cfg_reg.feed_rate   <= pwdata[15:0];
                REG_SPM_X:       cfg_reg.spm_x       <= pwdata[11:0];
                REG_SPM_Y:       cfg_reg.spm_y       <= pwdata[11:0];
                REG_SPM_Z:       cfg_reg.spm_z       <= pwdata[11:0];
                REG_SPM_E:       cfg_reg.spm_e       <= pwdata[11:0];
                REG_START_HP:    cfg_reg.start_hp    <= pwdata[15:0];
                REG_RAMP_FACTOR: cfg_reg.ramp_factor <= pwdata[15:0];
                default:         cfg_reg.abs_mode    <= cfg_reg.abs_mode;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_ABS_MODE:    prdata = {31'd0, cfg_reg.abs_mode};
            REG_FEED_RATE:   prdata = {16'd0, cfg_reg.feed_rate};
            REG_SPM_X:       prdata = {20'd0, cfg_reg.spm_x};
            REG_SPM_Y:       prdata = {20'd0, cfg_reg.spm_y};
            REG_SPM_Z:       prdata = {20'd0, cfg_reg.spm_z};
            REG_SPM_E:       prdata = {20'd0, cfg_reg.spm_e};
            REG_START_HP:    prdata = {16'd0, cfg_reg.start_hp};
            REG_RAMP_FACTOR: prdata = {16'd0, cfg_reg.ramp_factor};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

@@ src/fabs_ctrl.sv @@
// ----------------------------------------------------------------------------
// fabs_ctrl
// command sequencer: load, step, set-position and result handoff
// ----------------------------------------------------------------------------
`default_nettype none

module fabs_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [1:0]    in_cmd,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  fabs_pkg::dp_stat_t stat,
    output fabs_pkg::dp_cmd_t  cmd
);
    import fabs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_CALC,
        S_LD_MAG,
        S_LD_MINOR,
        S_LD_DIV,
        S_DIVIDE,
        S_ST_CALC,
        S_ST_PERIOD,
        S_RESULT
    } state_t;

    state_t state_reg;
    logic   in_ready_reg;
    logic   out_valid_reg;
    logic   accept;

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;
    assign accept    = in_valid & in_ready_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.capture  = accept;
        cmd.set_pos  = accept && (in_cmd == CMD_SET_POS);
        cmd.res_idle = accept && ((in_cmd != CMD_STEP) || stat.steps_zero);
        cmd.ld_calc  = (state_reg == S_LD_CALC);
        cmd.ld_mag   = (state_reg == S_LD_MAG);
        cmd.ld_minor = (state_reg == S_LD_MINOR);
        cmd.ld_div   = (state_reg == S_LD_DIV);
        cmd.div_step = (state_reg == S_DIVIDE);
        cmd.st_calc  = (state_reg == S_ST_CALC);
        cmd.st_period = (state_reg == S_ST_PERIOD);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        in_ready_reg <= 1'b0;
                        if (in_cmd == CMD_LOAD)
                        begin
                            state_reg <= S_LD_CALC;
                        end
                        else if ((in_cmd == CMD_STEP) && !stat.steps_zero)
                        begin
                            state_reg <= S_ST_CALC;
                        end
                        else
                        begin
                            state_reg     <= S_RESULT;
                            out_valid_reg <= 1'b1;
                        end
                    end
                end
                S_LD_CALC:   state_reg <= S_LD_MAG;
                S_LD_MAG:    state_reg <= S_LD_MINOR;
                S_LD_MINOR:  state_reg <= S_LD_DIV;
                S_LD_DIV:    state_reg <= S_DIVIDE;
                S_DIVIDE:
                begin
                    if (stat.div_done)
                    begin
                        state_reg     <= S_RESULT;
                        out_valid_reg <= 1'b1;
                    end
                end
                S_ST_CALC:   state_reg <= S_ST_PERIOD;
                S_ST_PERIOD:
                begin
                    state_reg     <= S_RESULT;
                    out_valid_reg <= 1'b1;
                end
                S_RESULT:
                begin
                    if (out_ready)
                    begin
                        state_reg     <= S_IDLE;
                        out_valid_reg <= 1'b0;
                        in_ready_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg     <= S_IDLE;
                    out_valid_reg <= 1'b0;
                    in_ready_reg  <= 1'b1;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ src/fabs_dp.sv @@
// ----------------------------------------------------------------------------
// fabs_dp
// line setup, bresenham error terms, period ramp and cruise divider
// ----------------------------------------------------------------------------
`default_nettype none

module fabs_dp #(
    parameter int POS_BITS = 24
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  fabs_pkg::cfg_t           cfg,
    input  fabs_pkg::dp_cmd_t        cmd,
    output fabs_pkg::dp_stat_t       stat,
    input  wire logic [3:0]          axis_mask,
    input  wire logic signed [23:0]  target_x,
    input  wire logic signed [23:0]  target_y,
    input  wire logic signed [23:0]  target_z,
    input  wire logic signed [23:0]  target_e,
    output logic [3:0]               step_bits,
    output logic [3:0]               dir_bits,
    output logic [24:0]              half_period,
    output logic                     last_step,
    output logic                     busy_res
);
    import fabs_pkg::*;

    localparam int DW = ((POS_BITS > 24) ? POS_BITS : 24) + 2;
    localparam logic signed [DW-1:0] D_MAX = DW'(16777215);
    localparam logic signed [DW-1:0] D_MIN = -(DW'(16777216));

    logic signed [POS_BITS-1:0] pos_reg [4];
    logic signed [23:0]         tgt_reg [4];
    logic signed [23:0]         tgt_in  [4];
    logic signed [24:0]         d_reg   [4];
    logic [24:0]                mag_reg [4];
    logic [1:0]                 best_reg;
    logic [3:0]                 dirs_reg;
    logic signed [24:0]         prev_x_reg, prev_y_reg;
    logic signed [49:0]         prod_x_reg, prod_y_reg;
    logic                       corner_reg;
    logic signed [26:0]         err_reg [3];
    logic [24:0]                mmag_reg [3];
    logic [24:0]                major_mag_reg;
    logic [1:0]                 major_reg;
    logic [24:0]                steps_left_reg;
    logic [24:0]                cruise_reg;
    logic [24:0]                cur_reg;
    logic [27:0]                divisor_reg;
    logic [27:0]                rem_reg;
    logic [4:0]                 cnt_reg;
    logic [40:0]                ramp_prod_reg;
    logic [3:0]                 res_step_reg;
    logic [24:0]                res_hp_reg;
    logic                       res_last_reg;

    // combinational helpers
    logic signed [DW-1:0]       t_ext [4];
    logic signed [DW-1:0]       p_ext [4];
    logic signed [DW-1:0]       d_raw [4];
    logic signed [DW-1:0]       p_sum [4];
    logic signed [24:0]         d_sat [4];
    logic [24:0]                mag_c [4];
    logic [1:0]                 best_c;
    logic [11:0]                spm_sel;
    logic signed [50:0]         dot;
    logic [28:0]                rem_sh;
    logic                       q_bit;
    logic [4:0]                 num_idx;
    logic [3:0]                 bits_c;
    logic signed [26:0]         err_c [3];
    logic                       use_ramp;
    logic [24:0]                cur_c;

    assign tgt_in[0] = target_x;
    assign tgt_in[1] = target_y;
    assign tgt_in[2] = target_z;
    assign tgt_in[3] = target_e;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            t_ext[i] = {{(DW-24){tgt_reg[i][23]}}, tgt_reg[i]};
            p_ext[i] = {{(DW-POS_BITS){pos_reg[i][POS_BITS-1]}}, pos_reg[i]};
            p_sum[i] = p_ext[i] + t_ext[i];
            d_raw[i] = cfg.abs_mode ? (t_ext[i] - p_ext[i]) : t_ext[i];
            if (d_raw[i] > D_MAX)
                d_sat[i] = D_MAX[24:0];
            else if (d_raw[i] < D_MIN)
                d_sat[i] = D_MIN[24:0];
            else
                d_sat[i] = d_raw[i][24:0];
            mag_c[i] = d_reg[i][24] ? (~d_reg[i] + 25'd1) : d_reg[i];
        end
        // first maximum wins on ties
        best_c = 2'd0;
        for (int i = 1; i < 4; i++)
        begin
            if (mag_c[i] > mag_c[best_c])
                best_c = 2'(i);
        end
    end

    always_comb
    begin
        case (best_reg)
            2'd0:    spm_sel = cfg.spm_x;
            2'd1:    spm_sel = cfg.spm_y;
            2'd2:    spm_sel = cfg.spm_z;
            default: spm_sel = cfg.spm_e;
        endcase
    end

    assign dot = 51'(prod_x_reg) + 51'(prod_y_reg);

    // restoring divider, one quotient bit per cycle; a zero divisor gives all ones
    assign num_idx = DIV_LAST - cnt_reg;
    assign rem_sh  = {rem_reg, CRUISE_NUM[num_idx]};
    assign q_bit   = (rem_sh >= {1'b0, divisor_reg});

    always_comb
    begin
        bits_c = 4'b0001 << major_reg;
        for (int j = 0; j < 3; j++)
        begin
            if (err_reg[j] > 27'sd0)
            begin
                bits_c = bits_c | (4'b0001 << ((j < int'(major_reg)) ? j : j + 1));
                err_c[j] = err_reg[j] + $signed({1'b0, mmag_reg[j], 1'b0})
                         - $signed({1'b0, major_mag_reg, 1'b0});
            end
            else
            begin
                err_c[j] = err_reg[j] + $signed({1'b0, mmag_reg[j], 1'b0});
            end
        end
    end

    always_comb
    begin
        use_ramp = ((major_reg <= AXIS_Y) && corner_reg) || (major_reg == AXIS_Z);
        if (!use_ramp)
            cur_c = cruise_reg;
        else if (cur_reg > cruise_reg)
            cur_c = ramp_prod_reg[40:16];
        else
            cur_c = cur_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                pos_reg[i] <= '0;
            end
            for (int j = 0; j < 3; j++)
            begin
                err_reg[j]  <= '0;
                mmag_reg[j] <= '0;
            end
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            major_mag_reg  <= '0;
            major_reg      <= '0;
            steps_left_reg <= '0;
            dirs_reg       <= 4'hF;
            cruise_reg     <= '0;
            cur_reg        <= '0;
            corner_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.set_pos)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    if (axis_mask[i])
                        pos_reg[i] <= POS_BITS'({{(DW-24){tgt_in[i][23]}}, tgt_in[i]});
                end
            end
            if (cmd.ld_calc)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    pos_reg[i] <= cfg.abs_mode ? t_ext[i][POS_BITS-1:0]
                                               : p_sum[i][POS_BITS-1:0];
                end
            end
            if (cmd.ld_mag)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    dirs_reg[i] <= ~d_reg[i][24];
                end
            end
            if (cmd.ld_minor)
            begin
                prev_x_reg     <= d_reg[0];
                prev_y_reg     <= d_reg[1];
                major_reg      <= best_reg;
                major_mag_reg  <= mag_reg[best_reg];
                steps_left_reg <= mag_reg[best_reg];
                cur_reg        <= {9'd0, cfg.start_hp};
                for (int j = 0; j < 3; j++)
                begin
                    mmag_reg[j] <= mag_reg[(j < int'(best_reg)) ? j : j + 1];
                    err_reg[j]  <= $signed({1'b0, mag_reg[(j < int'(best_reg)) ? j : j + 1],
                                            1'b0})
                                 - $signed({2'b0, mag_reg[best_reg]});
                end
            end
            if (cmd.ld_div)
            begin
                corner_reg <= !(dot > 51'sd0);
            end
            if (cmd.div_step)
            begin
                cruise_reg <= {cruise_reg[QUO_BITS-2:0], q_bit};
            end
            if (cmd.st_calc)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    err_reg[j] <= err_c[j];
                end
                steps_left_reg <= steps_left_reg - 25'd1;
            end
            if (cmd.st_period)
            begin
                cur_reg <= cur_c;
            end
        end
    end

    // payload and working registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            for (int i = 0; i < 4; i++)
            begin
                tgt_reg[i] <= tgt_in[i];
            end
        end
        if (cmd.res_idle)
        begin
            res_step_reg <= 4'd0;
            res_hp_reg   <= 25'd0;
            res_last_reg <= 1'b0;
        end
        if (cmd.ld_calc)
        begin
            for (int i = 0; i < 4; i++)
            begin
                d_reg[i] <= d_sat[i];
            end
            res_step_reg <= 4'd0;
            res_hp_reg   <= 25'd0;
            res_last_reg <= 1'b0;
        end
        if (cmd.ld_mag)
        begin
            for (int i = 0; i < 4; i++)
            begin
                mag_reg[i] <= mag_c[i];
            end
            best_reg   <= best_c;
            prod_x_reg <= prev_x_reg * d_reg[0];
        end
        if (cmd.ld_minor)
        begin
            prod_y_reg <= prev_y_reg * d_reg[1];
        end
        if (cmd.ld_div)
        begin
            divisor_reg <= {16'd0, spm_sel} * {12'd0, cfg.feed_rate};
            rem_reg     <= '0;
            cnt_reg     <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= q_bit ? 28'(rem_sh - {1'b0, divisor_reg}) : rem_sh[27:0];
            cnt_reg <= cnt_reg + 5'd1;
        end
        if (cmd.st_calc)
        begin
            res_step_reg  <= bits_c;
            ramp_prod_reg <= {16'd0, cur_reg} * {25'd0, cfg.ramp_factor};
        end
        if (cmd.st_period)
        begin
            res_hp_reg   <= cur_c;
            res_last_reg <= (steps_left_reg == 25'd0);
        end
    end

    assign stat.steps_zero = (steps_left_reg == 25'd0);
    assign stat.div_done   = (cnt_reg == DIV_LAST);

    assign step_bits   = res_step_reg;
    assign dir_bits    = dirs_reg;
    assign half_period = res_hp_reg;
    assign last_step   = res_last_reg;
    assign busy_res    = (steps_left_reg != 25'd0);

endmodule

`default_nettype wire

@@ sim/fabs_step_checker.sv @@
// ----------------------------------------------------------------------------
// fabs_step_checker
// watches command and result beats, predicts each result and compares it
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module fabs_step_checker
    import fabs_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    fabs_in_if.sink    in_mon,
    fabs_out_if.sink   out_mon,
    input  cfg_t       cfg,
    output int         fail_count,
    output int         pending,
    output int         steps_seen,
    output int         loads_seen
);

    typedef struct packed {
        logic [3:0]  step_bits;
        logic [3:0]  dir_bits;
        logic [24:0] half_period;
        logic        last_step;
        logic        busy_res;
    } step_res_t;

    step_res_t result_queue[$];

    logic signed [23:0] pos [4];
    logic signed [24:0] prev_dx, prev_dy;
    logic signed [26:0] err [3];
    logic [24:0] min_mag [3];
    logic [24:0] maj_mag;
    logic [1:0]  maj_axis;
    logic [24:0] left;
    logic [3:0]  dirs;
    logic [24:0] cruise, cur_hp;
    logic        corner;

    function automatic logic [24:0] ramped(logic [24:0] p);
        logic [40:0] prod;
        if (p > cruise)
        begin
            prod = p * cfg.ramp_factor;
            return prod[40:16];
        end
        return p;
    endfunction

    function automatic step_res_t idle_res();
        step_res_t r;
        r = '0;
        r.dir_bits = dirs;
        r.busy_res = (left != 0);
        return r;
    endfunction

    task automatic predict_load(logic signed [23:0] tgt [4]);
        logic signed [25:0] d [4];
        logic [24:0] mag [4];
        logic signed [63:0] dot;
        logic [23:0] spm [4];
        logic [27:0] div;
        int best;
        int ax;
        best = 0;
        for (int i = 0; i < 4; i++)
        begin
            if (cfg.abs_mode)
            begin
                d[i] = tgt[i] - pos[i];
                pos[i] = tgt[i];
            end
            else
            begin
                d[i] = tgt[i];
                pos[i] = pos[i] + tgt[i];
            end
        end
        dot = prev_dx * d[0] + prev_dy * d[1];
        corner = !(dot > 0);
        prev_dx = d[0];
        prev_dy = d[1];
        dirs = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (d[i] < 0)
                mag[i] = -d[i];
            else
            begin
                mag[i] = d[i];
                dirs[i] = 1'b1;
            end
            if (mag[i] > mag[best])
                best = i;
        end
        maj_axis = best;
        maj_mag = mag[best];
        left = mag[best];
        for (int j = 0; j < 3; j++)
        begin
            ax = (j < best) ? j : j + 1;
            min_mag[j] = mag[ax];
            err[j] = 2 * $signed({2'b0, mag[ax]}) - $signed({2'b0, mag[best]});
        end
        spm[0] = cfg.spm_x;
        spm[1] = cfg.spm_y;
        spm[2] = cfg.spm_z;
        spm[3] = cfg.spm_e;
        div = spm[best] * cfg.feed_rate;
        cruise = (div == 0) ? 25'h1FFFFFF : 25'(30000000 / div);
        cur_hp = cfg.start_hp;
    endtask

    function automatic step_res_t predict_step();
        step_res_t r;
        int ax;
        if (left == 0)
            return idle_res();
        r = '0;
        r.step_bits[maj_axis] = 1'b1;
        for (int j = 0; j < 3; j++)
        begin
            ax = (j < maj_axis) ? j : j + 1;
            if (err[j] > 0)
            begin
                r.step_bits[ax] = 1'b1;
                err[j] = err[j] + 2 * ($signed({2'b0, min_mag[j]})
                                       - $signed({2'b0, maj_mag}));
            end
            else
                err[j] = err[j] + 2 * $signed({2'b0, min_mag[j]});
        end
        if (maj_axis <= AXIS_Y)
            cur_hp = corner ? ramped(cur_hp) : cruise;
        else if (maj_axis == AXIS_Z)
            cur_hp = ramped(cur_hp);
        else
            cur_hp = cruise;
        left = left - 1;
        r.dir_bits = dirs;
        r.half_period = cur_hp;
        r.last_step = (left == 0);
        r.busy_res = (left != 0);
        return r;
    endfunction

    assign pending = result_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        step_res_t exp_r;
        step_res_t got;
        logic signed [23:0] tgt [4];
        if (!rst_n)
        begin
            result_queue.delete();
            for (int i = 0; i < 4; i++)
                pos[i] = '0;
            prev_dx = '0;
            prev_dy = '0;
            for (int j = 0; j < 3; j++)
            begin
                err[j] = '0;
                min_mag[j] = '0;
            end
            maj_mag = '0;
            maj_axis = '0;
            left = '0;
            dirs = 4'hF;
            cruise = '0;
            cur_hp = '0;
            corner = 1'b0;
            fail_count = 0;
            steps_seen = 0;
            loads_seen = 0;
        end
        else
        begin
            if (out_mon.valid && out_mon.ready)
            begin
                got = '{out_mon.step_bits, out_mon.dir_bits, out_mon.half_period,
                        out_mon.last_step, out_mon.busy_res};
                if (got.step_bits != 0)
                    steps_seen++;
                if (result_queue.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result beat %h", got);
                end
                else
                begin
                    exp_r = result_queue.pop_front();
                    if (got !== exp_r)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: step %h/%h dir %h/%h hp %0d/%0d last %b/%b busy %b/%b",
                                     exp_r.step_bits, got.step_bits, exp_r.dir_bits,
                                     got.dir_bits, exp_r.half_period, got.half_period,
                                     exp_r.last_step, got.last_step, exp_r.busy_res,
                                     got.busy_res);
                    end
                end
            end
            if (in_mon.valid && in_mon.ready)
            begin
                tgt[0] = in_mon.target_x;
                tgt[1] = in_mon.target_y;
                tgt[2] = in_mon.target_z;
                tgt[3] = in_mon.target_e;
                case (in_mon.cmd)
                    CMD_LOAD:
                    begin
                        predict_load(tgt);
                        loads_seen++;
                        result_queue.push_back(idle_res());
                    end
                    CMD_STEP:
                        result_queue.push_back(predict_step());
                    CMD_SET_POS:
                    begin
                        for (int i = 0; i < 4; i++)
                            if (in_mon.axis_mask[i])
                                pos[i] = tgt[i];
                        result_queue.push_back(idle_res());
                    end
                    default:
                        result_queue.push_back(idle_res());
                endcase
            end
        end
    end

endmodule

`default_nettype wire

@@ sim/four_axis_bresenham_stepper_top_test.sv @@
// ----------------------------------------------------------------------------
// four_axis_bresenham_stepper_top_test
// drives command beats and register writes; a checker beside the block
// predicts every result beat and counts mismatches
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module four_axis_bresenham_stepper_top_test;
    import fabs_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // shadow of the register file so the checker predicts with the same values
    cfg_t cfg;

    int  fail_count, pending, steps_seen, loads_seen;
    int  cycle_count = 0;
    bit  no_idle;   // stretch with no gaps on either side

    fabs_in_if  in_ch ();
    fabs_out_if out_ch ();

    four_axis_bresenham_stepper_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    fabs_step_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_mon     (in_ch.sink),
        .out_mon    (out_ch.sink),
        .cfg        (cfg),
        .fail_count (fail_count),
        .pending    (pending),
        .steps_seen (steps_seen),
        .loads_seen (loads_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // timeout watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("four_axis_bresenham_stepper_top_test failed");
            $finish;
        end
    end

    // result side: random stalls unless inside the no-idle stretch
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 9);
    end

    // apb write: setup then access, register lands on the access edge
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ABS_MODE:    cfg.abs_mode    = val[0];
            REG_FEED_RATE:   cfg.feed_rate   = val[15:0];
            REG_SPM_X:       cfg.spm_x       = val[11:0];
            REG_SPM_Y:       cfg.spm_y       = val[11:0];
            REG_SPM_Z:       cfg.spm_z       = val[11:0];
            REG_SPM_E:       cfg.spm_e       = val[11:0];
            REG_START_HP:    cfg.start_hp    = val[15:0];
            default:         cfg.ramp_factor = val[15:0];
        endcase
    endtask

    // one command beat; valid stays high back to back in the no-idle stretch, else random gaps
    task automatic send_cmd(logic [1:0] c, logic [3:0] m, logic signed [23:0] tx,
                            logic signed [23:0] ty, logic signed [23:0] tz,
                            logic signed [23:0] te);
        while (!no_idle && $urandom_range(0, 99) < 9)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= c;
        in_ch.axis_mask <= m;
        in_ch.target_x  <= tx;
        in_ch.target_y  <= ty;
        in_ch.target_z  <= tz;
        in_ch.target_e  <= te;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // drop valid and wait until every result is back, plus the divider time
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // mostly small moves so lines finish; now and then a full-range value
    function automatic logic signed [23:0] rand_target();
        case ($urandom_range(0, 9))
            0:       return 24'($urandom);
            1:       return $signed(24'($urandom_range(0, 60))) - 24'sd30;
            default: return $signed(24'($urandom_range(0, 24))) - 24'sd12;
        endcase
    endfunction

    // a load, its steps (sometimes cut short or overrun), a few stray beats
    task automatic random_line(inout int items);
        logic signed [23:0] t [4];
        logic [1:0] c;
        int n;
        for (int i = 0; i < 4; i++)
            t[i] = rand_target();
        send_cmd(CMD_LOAD, 4'($urandom), t[0], t[1], t[2], t[3]);
        items++;
        n = $urandom_range(0, 40);
        for (int k = 0; k < n; k++)
        begin
            c = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(2, 3)) : CMD_STEP;
            send_cmd(c, 4'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                     24'($urandom));
            items++;
        end
    endtask

    initial
    begin
        int items;
        items = 0;
        no_idle = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_LOAD;
        in_ch.axis_mask = '0;
        in_ch.target_x = '0;
        in_ch.target_y = '0;
        in_ch.target_z = '0;
        in_ch.target_e = '0;
        cfg = '{1'b1, 16'd500, 12'd80, 12'd80, 12'd400, 12'd100, 16'd300, 16'd64880};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle step, odd command, extremes of positions and targets
        send_cmd(CMD_STEP, 4'h0, 0, 0, 0, 0);
        send_cmd(2'd3, 4'hF, 0, 0, 0, 0);
        send_cmd(CMD_SET_POS, 4'hF, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000);
        send_cmd(CMD_LOAD, 4'h0, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
        send_cmd(CMD_STEP, 4'h0, 0, 0, 0, 0);
        send_cmd(CMD_SET_POS, 4'h5, 0, 24'sh123456, 0, 24'sh654321);
        send_cmd(CMD_SET_POS, 4'hA, 24'sh0, 24'sh0, 24'sh0, 24'sh0);
        send_cmd(CMD_SET_POS, 4'h5, 24'sh0, 24'sh0, 24'sh0, 24'sh0);
        // zero-length line, then x, z and e dominant short lines, tie on x/y
        send_cmd(CMD_LOAD, 4'h0, 0, 0, 0, 0);
        send_cmd(CMD_STEP, 4'h0, 0, 0, 0, 0);
        send_cmd(CMD_LOAD, 4'h0, 5, 5, -2, 1);
        repeat (6) send_cmd(CMD_STEP, 4'h0, 0, 0, 0, 0);
        send_cmd(CMD_LOAD, 4'h0, 9, 9, 1, 1);
        send_cmd(CMD_STEP, 4'h0, 0, 0, 0, 0);
        send_cmd(CMD_LOAD, 4'h0, 8, 7, 20, 1);
        repeat (4) send_cmd(CMD_STEP, 4'h0, 0, 0, 0, 0);
        send_cmd(CMD_LOAD, 4'h0, 8, 7, 20, -10);
        repeat (3) send_cmd(CMD_STEP, 4'h0, 0, 0, 0, 0);
        items = 28;
        // sender pauses until every result has come back
        drain();

        // several register settings, extremes included
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(REG_ABS_MODE, 0);
                    write_reg(REG_FEED_RATE, 65535);
                    write_reg(REG_SPM_X, 4095);
                    write_reg(REG_SPM_Y, 1);
                    write_reg(REG_SPM_Z, 4095);
                    write_reg(REG_SPM_E, 1);
                    write_reg(REG_START_HP, 65535);
                    write_reg(REG_RAMP_FACTOR, 65535);
                end
                1:
                begin
                    write_reg(REG_FEED_RATE, 1);
                    write_reg(REG_SPM_X, 1);
                    write_reg(REG_SPM_Y, 4095);
                    write_reg(REG_SPM_Z, 1);
                    write_reg(REG_SPM_E, 4095);
                    write_reg(REG_START_HP, 0);
                    write_reg(REG_RAMP_FACTOR, 0);
                end
                default:
                begin
                    write_reg(REG_ABS_MODE, $urandom_range(0, 1));
                    write_reg(REG_FEED_RATE, $urandom_range(1, 65535));
                    write_reg(REG_SPM_X, $urandom_range(1, 4095));
                    write_reg(REG_SPM_Y, $urandom_range(1, 4095));
                    write_reg(REG_SPM_Z, $urandom_range(1, 4095));
                    write_reg(REG_SPM_E, $urandom_range(1, 4095));
                    write_reg(REG_START_HP, $urandom_range(0, 65535));
                    write_reg(REG_RAMP_FACTOR, $urandom_range(32768, 65535));
                end
            endcase
            no_idle = (phase == 3);
            while (items < 25 + 180 * (phase + 1))
                random_line(items);
            drain();
        end

        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        $display("covered %0d command beats, %0d line loads, %0d step beats",
                 items, loads_seen, steps_seen);
        $display("six register settings with both extremes, directed corners included");
        if (fail_count == 0)
            $display("four_axis_bresenham_stepper_top_test passed");
        else
            $display("four_axis_bresenham_stepper_top_test failed");
        $finish;
    end

endmodule

`default_nettype wire
